// ===== design/yhpd_pkg.sv =====
// ----------------------------------------------------------------------------
// yhpd_pkg: shared types and constants of the yaw heading-hold controller
// Holds the stream item layout, the register map, the controller state codes
// and the fixed constants of the heading wrap.
// ----------------------------------------------------------------------------
package yhpd_pkg;

  // Stream payload widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic        [15:0] step_time;
    logic signed [18:0] gyro_rate;
    logic signed [16:0] yaw_meas;
    logic signed [15:0] user_rate;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_x;
  } in_item_t;

  localparam int IN_ITEM_W = $bits(in_item_t);

  // Configuration registers
  typedef struct packed {
    logic [14:0] omega_deadband;
    logic [14:0] move_deadband;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [14:0] integral_limit;
    logic [14:0] output_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    omega_deadband: 15'd100,
    move_deadband:  15'd100,
    gain_p:         16'd256,
    gain_i:         16'd64,
    gain_d:         16'd32,
    integral_limit: 15'd3000,
    output_limit:   15'd30000
  };

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA_DB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_DB   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM   = 3'd6;

  // Result mode codes
  typedef enum logic [1:0] {
    MODE_USER = 2'd0,
    MODE_HOLD = 2'd1,
    MODE_IDLE = 2'd2
  } mode_e;

  // Controller sequence
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_LOAD,
    ST_RUN,
    ST_POST,
    ST_WRAP,
    ST_SUM,
    ST_CLAMP,
    ST_DONE
  } state_e;

  // Products run on the serial multiplier, in this order
  typedef enum logic [2:0] {
    OP_VX2,
    OP_VY2,
    OP_MD2,
    OP_GI,
    OP_DT,
    OP_GP,
    OP_GD
  } mul_op_e;

  // Serial multiplier geometry
  localparam int MUL_M_W   = 34;
  localparam int MUL_R_W   = 16;
  localparam int MUL_CNT_W = 4;
  localparam int MUL_P_W   = MUL_M_W + 1 + MUL_R_W;

  // Heading wrap, 0.01 degree units
  localparam int ERR_W = 19;
  localparam logic [ERR_W-1:0] WRAP_OFFSET = 19'd144000;
  localparam logic [ERR_W-1:0] TURN        = 19'd36000;
  localparam logic [ERR_W-1:0] HALF_TURN   = 19'd18000;

endpackage

// ===== design/yaw_hold_pi_damped.sv =====
// ----------------------------------------------------------------------------
// yaw_hold_pi_damped: yaw heading hold with PI control and gyro damping
// Streams one rotation-rate command per input item, computed on a bit-serial
// shift-add multiplier that is shared by all products of the control law.
// ----------------------------------------------------------------------------
// A user rotation above omega_deadband passes straight through (mode 0) and
// releases the hold. Otherwise translation with vel_x^2 + vel_y^2 above
// move_deadband^2 engages the hold (mode 1): the yaw of the first hold item
// becomes the target, and the output is a Q8.8 PI law on the heading error,
// wrapped to half a turn, minus gyro damping, with the integral clamped to
// +-integral_limit and the output to +-output_limit. With neither, the output
// is zero (mode 2) and the hold is cleared. Items are taken one at a time;
// the pace is set by the serial multiplier, which forms one product bit per
// cycle and runs seven products of a 16-bit multiplier in turn (three for
// the translation test, four for the control law), each framed by a load and
// a post step; an idle item runs the first three only, a pass-through item
// none. A finished result sits in an output register, so the next item is
// taken while it waits. Configuration writes are taken in any cycle; write only
// between items.
// ----------------------------------------------------------------------------
module yaw_hold_pi_damped (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // vel_x[15:0], vel_y[31:16], user_rate[47:32], yaw_meas[64:48],
  // gyro_rate[83:65], step_time[99:84], zero pad[103:100]
  input  logic [yhpd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // rate_out[15:0]
  output logic [yhpd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // mode[1:0]
  output logic [yhpd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [yhpd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [yhpd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import yhpd_pkg::*;

  localparam logic [MUL_CNT_W-1:0] MUL_LAST   = MUL_CNT_W'(MUL_R_W - 1);
  localparam logic [2:0]           WRAP_FIRST = 3'd0;
  localparam logic [2:0]           WRAP_LAST  = 3'd4;
  localparam logic signed [52:0]   ROUND_HALF = 53'sd8388608;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                      state_q, state_d;
  mul_op_e                     op_q, op_d;
  cfg_t                        cfg_q, cfg_d;
  in_item_t                    item_q, item_d;

  // controller state carried between items
  logic                        hold_q, hold_d;
  logic signed [16:0]          target_q, target_d;
  logic signed [39:0]          integ_q, integ_d;

  // serial multiplier: multiplicand, upper partial sum, multiplier shift line
  logic signed [MUL_M_W-1:0]   mul_m_q, mul_m_d;
  logic signed [MUL_M_W:0]     mul_hi_q, mul_hi_d;
  logic        [MUL_R_W-1:0]   mul_lo_q, mul_lo_d;
  logic        [MUL_CNT_W-1:0] cnt_q, cnt_d;

  // intermediate results
  logic        [31:0]          sq_q, sq_d;
  logic signed [31:0]          t1_q, t1_d;
  logic signed [35:0]          pd_q, pd_d;
  logic        [ERR_W-1:0]     err_q, err_d;
  logic        [ERR_W-1:0]     mod_q, mod_d;
  logic        [2:0]           wrap_q, wrap_d;
  logic signed [28:0]          rate_full_q, rate_full_d;
  logic        [15:0]          res_rate_q, res_rate_d;
  mode_e                       res_mode_q, res_mode_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic        [15:0]          out_rate_q, out_rate_d;
  mode_e                       out_mode_q, out_mode_d;

  // --------------------------------------------------------------------------
  // Shared combinational terms
  // --------------------------------------------------------------------------
  logic                        in_fire;
  logic                        out_free;
  logic signed [16:0]          ur_ext, vx_ext, vy_ext;
  logic        [16:0]          mag_u, abs_vx, abs_vy;
  logic                        is_user;
  logic signed [MUL_M_W-1:0]   m_sel;
  logic        [MUL_R_W-1:0]   r_sel;
  logic signed [MUL_M_W:0]     mul_sum;
  logic signed [MUL_P_W-1:0]   prod;
  logic                        is_moving;
  logic signed [ERR_W-1:0]     err_s;
  logic signed [19:0]          diff;
  logic signed [47:0]          integ_sum, ilim, integ_sel;
  logic signed [52:0]          sum_full;
  logic signed [28:0]          olim, rate_clamp;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // magnitudes; the most negative value maps onto its positive magnitude
  assign ur_ext  = 17'(item_q.user_rate);
  assign vx_ext  = 17'(item_q.vel_x);
  assign vy_ext  = 17'(item_q.vel_y);
  assign mag_u   = item_q.user_rate[15] ? -ur_ext : ur_ext;
  assign abs_vx  = item_q.vel_x[15] ? -vx_ext : vx_ext;
  assign abs_vy  = item_q.vel_y[15] ? -vy_ext : vy_ext;
  assign is_user = mag_u > {2'b00, cfg_q.omega_deadband};

  assign err_s = $signed(err_q);

  // operand select for the next product
  always_comb begin
    unique case (op_q)
      OP_VX2: begin
        m_sel = MUL_M_W'(abs_vx);
        r_sel = abs_vx[MUL_R_W-1:0];
      end
      OP_VY2: begin
        m_sel = MUL_M_W'(abs_vy);
        r_sel = abs_vy[MUL_R_W-1:0];
      end
      OP_MD2: begin
        m_sel = MUL_M_W'(cfg_q.move_deadband);
        r_sel = MUL_R_W'(cfg_q.move_deadband);
      end
      OP_GI: begin
        m_sel = MUL_M_W'(err_s);
        r_sel = cfg_q.gain_i;
      end
      OP_DT: begin
        m_sel = MUL_M_W'(t1_q);
        r_sel = item_q.step_time;
      end
      OP_GP: begin
        m_sel = MUL_M_W'(err_s);
        r_sel = cfg_q.gain_p;
      end
      OP_GD: begin
        m_sel = MUL_M_W'(item_q.gyro_rate);
        r_sel = cfg_q.gain_d;
      end
      default: begin
        m_sel = '0;
        r_sel = '0;
      end
    endcase
  end

  // one multiplier bit per cycle: add the multiplicand, then shift right
  assign mul_sum = mul_hi_q + (mul_lo_q[0] ? (MUL_M_W + 1)'(mul_m_q) : '0);
  assign prod    = $signed({mul_hi_q, mul_lo_q});

  // translation test against the squared deadband
  assign is_moving = sq_q > prod[31:0];

  // heading error before reduction, always positive
  assign diff = 20'(target_q) - 20'(item_q.yaw_meas) + 20'($signed(WRAP_OFFSET));

  // integral update and clamp at scale 2^-24
  assign integ_sum = 48'(integ_q) + $signed(prod[47:0]);
  assign ilim      = 48'({cfg_q.integral_limit, 24'd0});
  always_comb begin
    if (integ_sum > ilim) begin
      integ_sel = ilim;
    end else if (integ_sum < -ilim) begin
      integ_sel = -ilim;
    end else begin
      integ_sel = integ_sum;
    end
  end

  // P minus D at scale 2^-8 lifted to 2^-24, plus I, plus half an LSB
  assign sum_full = (53'(pd_q) <<< 16) + 53'(integ_q) + ROUND_HALF;

  assign olim = $signed(29'(cfg_q.output_limit));
  always_comb begin
    if (rate_full_q > olim) begin
      rate_clamp = olim;
    end else if (rate_full_q < -olim) begin
      rate_clamp = -olim;
    end else begin
      rate_clamp = rate_full_q;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OMEGA_DB:  cfg_d.omega_deadband = cfg_data_i[14:0];
        REG_MOVE_DB:   cfg_d.move_deadband  = cfg_data_i[14:0];
        REG_GAIN_P:    cfg_d.gain_p         = cfg_data_i;
        REG_GAIN_I:    cfg_d.gain_i         = cfg_data_i;
        REG_GAIN_D:    cfg_d.gain_d         = cfg_data_i;
        REG_INTEG_LIM: cfg_d.integral_limit = cfg_data_i[14:0];
        REG_OUT_LIM:   cfg_d.output_limit   = cfg_data_i[14:0];
        default:       ; // drop writes beyond the register map
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_CLASSIFY;
      ST_CLASSIFY: state_d = is_user ? ST_DONE : ST_LOAD;
      ST_LOAD:     state_d = ST_RUN;
      ST_RUN:      if (cnt_q == MUL_LAST) state_d = ST_POST;
      ST_POST: begin
        unique case (op_q)
          OP_MD2:  state_d = is_moving ? ST_WRAP : ST_DONE;
          OP_GD:   state_d = ST_SUM;
          default: state_d = ST_LOAD;
        endcase
      end
      ST_WRAP:     if (wrap_q == WRAP_LAST) state_d = ST_LOAD;
      ST_SUM:      state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and state updates per step
  // --------------------------------------------------------------------------
  always_comb begin
    op_d        = op_q;
    item_d      = item_q;
    hold_d      = hold_q;
    target_d    = target_q;
    integ_d     = integ_q;
    mul_m_d     = mul_m_q;
    mul_hi_d    = mul_hi_q;
    mul_lo_d    = mul_lo_q;
    cnt_d       = cnt_q;
    sq_d        = sq_q;
    t1_d        = t1_q;
    pd_d        = pd_q;
    err_d       = err_q;
    mod_d       = mod_q;
    wrap_d      = wrap_q;
    rate_full_d = rate_full_q;
    res_rate_d  = res_rate_q;
    res_mode_d  = res_mode_q;
    out_rate_d  = out_rate_q;
    out_mode_d  = out_mode_q;

    // drop the result once the downstream side has taken it
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          item_d = in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
        end
      end

      ST_CLASSIFY: begin
        if (is_user) begin
          // pass the user command through and release the hold
          hold_d     = 1'b0;
          integ_d    = '0;
          res_rate_d = item_q.user_rate;
          res_mode_d = MODE_USER;
        end else begin
          op_d = OP_VX2;
        end
      end

      ST_LOAD: begin
        mul_m_d  = m_sel;
        mul_hi_d = '0;
        mul_lo_d = r_sel;
        cnt_d    = '0;
      end

      ST_RUN: begin
        mul_hi_d = mul_sum >>> 1;
        mul_lo_d = {mul_sum[0], mul_lo_q[MUL_R_W-1:1]};
        cnt_d    = cnt_q + 1'b1;
      end

      ST_POST: begin
        unique case (op_q)
          OP_VX2: begin
            sq_d = prod[31:0];
            op_d = OP_VY2;
          end
          OP_VY2: begin
            sq_d = sq_q + prod[31:0];
            op_d = OP_MD2;
          end
          OP_MD2: begin
            if (is_moving) begin
              // capture the heading once on engagement
              if (!hold_q) begin
                hold_d   = 1'b1;
                target_d = item_q.yaw_meas;
                integ_d  = '0;
              end
              wrap_d = WRAP_FIRST;
            end else begin
              hold_d     = 1'b0;
              integ_d    = '0;
              res_rate_d = '0;
              res_mode_d = MODE_IDLE;
            end
          end
          OP_GI: begin
            t1_d = $signed(prod[31:0]);
            op_d = OP_DT;
          end
          OP_DT: begin
            integ_d = integ_sel[39:0];
            op_d    = OP_GP;
          end
          OP_GP: begin
            pd_d = $signed(prod[35:0]);
            op_d = OP_GD;
          end
          OP_GD: begin
            pd_d = pd_q - $signed(prod[35:0]);
          end
          default: ;
        endcase
      end

      ST_WRAP: begin
        // reduce modulo one turn by restoring subtraction of 4, 2, 1 turns,
        // then center onto half a turn
        wrap_d = wrap_q + 1'b1;
        if (wrap_q == WRAP_FIRST) begin
          err_d = diff[ERR_W-1:0];
          mod_d = WRAP_OFFSET;
        end else if (wrap_q == WRAP_LAST) begin
          if (err_q > HALF_TURN) begin
            err_d = err_q - TURN;
          end
          op_d = OP_GI;
        end else begin
          if (err_q >= mod_q) begin
            err_d = err_q - mod_q;
          end
          mod_d = mod_q >> 1;
        end
      end

      ST_SUM: begin
        // floor of the biased sum gives round to nearest, ties up
        rate_full_d = sum_full[52:24];
      end

      ST_CLAMP: begin
        res_rate_d = rate_clamp[15:0];
        res_mode_d = MODE_HOLD;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rate_d  = res_rate_q;
          out_mode_d  = res_mode_q;
        end
      end

      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      hold_q      <= 1'b0;
      target_q    <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      hold_q      <= hold_d;
      target_q    <= target_d;
      integ_q     <= integ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    item_q      <= item_d;
    mul_m_q     <= mul_m_d;
    mul_hi_q    <= mul_hi_d;
    mul_lo_q    <= mul_lo_d;
    cnt_q       <= cnt_d;
    sq_q        <= sq_d;
    t1_q        <= t1_d;
    pd_q        <= pd_d;
    err_q       <= err_d;
    mod_q       <= mod_d;
    wrap_q      <= wrap_d;
    rate_full_q <= rate_full_d;
    res_rate_q  <= res_rate_d;
    res_mode_q  <= res_mode_d;
    out_rate_q  <= out_rate_d;
    out_mode_q  <= out_mode_d;
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rate_q;
  assign m_axis_tuser  = out_mode_q;

endmodule

// ===== design/yhpd_checker.sv =====
// ----------------------------------------------------------------------------
// yhpd_checker: port-level checks of the yaw heading-hold controller
// Watches the stream ports over time and flags results that break the mode
// rules or the one-item-at-a-time sequence.
// ----------------------------------------------------------------------------
module yhpd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [yhpd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [yhpd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
  import yhpd_pkg::*;

  // hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a result carries one of the three modes
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == MODE_USER || m_axis_tuser == MODE_HOLD ||
       m_axis_tuser == MODE_IDLE))
    else $error("result with unknown mode");

  // idle results command zero rotation
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == MODE_IDLE) |-> (m_axis_tdata == '0))
    else $error("idle result with nonzero rate");

  // pass-through only happens above the deadband, so the rate is never zero
  a_user_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == MODE_USER) |-> (m_axis_tdata != '0))
    else $error("pass-through result with zero rate");

  // one item at a time: the input side closes after every transaction
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

endmodule

bind yaw_hold_pi_damped yhpd_checker u_yhpd_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of the yaw heading-hold PI controller
// A queue-fed driver pushes control-loop items into the block while a monitor
// checks each result against a cycle-free model of the hold law. The run goes
// through several register settings and idle/stall profiles on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import yhpd_pkg::*;

  // Clock period is 12 ns; the run is capped by a cycle counter
  localparam int CYCLE_LIMIT   = 1_500_000;
  // Give a margin after the last result
  localparam int SETTLE_CYCLES = 200;
  localparam int ITEMS_PER_SEG = 200;
  localparam int NUM_SEGS      = 8;

  // Unmapped register index, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Fixed-point constants of the hold law, 0.01 degree and 2^-24 scales
  localparam longint TURN_CDEG   = 36000;
  localparam longint HALF_CDEG   = 18000;
  localparam longint WRAP_BIAS   = 144000;
  localparam longint UNIT_SCALE  = 64'sd16777216;
  localparam longint HALF_SCALE  = 64'sd8388608;
  localparam longint GAIN_SCALE  = 64'sd65536;

  typedef struct packed {
    logic [15:0] rate;
    mode_e       mode;
  } rate_cmd_t;

  typedef struct {
    in_item_t item;
    bit       wait_empty;  // hold the item back until no result is pending
  } stim_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  yaw_hold_pi_damped u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // --------------------------------------------------------------------------
  // Hold-law model: register copy and controller state
  // --------------------------------------------------------------------------
  cfg_t   cfg_model  = CFG_RESET;
  bit     hold_on    = 1'b0;
  longint target_hdg = 0;
  longint integ_acc  = 0;

  stim_t     stim_q[$];      // items waiting for the driver
  rate_cmd_t rate_cmd_q[$];  // expected results, oldest first
  stim_t     bus_stim;       // item currently offered on the input stream

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int errors         = 0;
  int cycle_cnt      = 0;
  int hold_left      = 0;    // items left in the current hold run
  int yaw_walk       = 0;    // drifting heading used inside a hold run

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance the controller by one item and return the command it yields
  function automatic rate_cmd_t hold_law_step(input in_item_t it);
    longint vx, vy, ur, yaw, gyro, dt, mag_u, err, sum, rate;
    longint od, mdb;
    rate_cmd_t res;
    vx    = longint'($signed(it.vel_x));
    vy    = longint'($signed(it.vel_y));
    ur    = longint'($signed(it.user_rate));
    yaw   = longint'($signed(it.yaw_meas));
    gyro  = longint'($signed(it.gyro_rate));
    dt    = longint'(it.step_time);
    od    = longint'(cfg_model.omega_deadband);
    mdb   = longint'(cfg_model.move_deadband);
    mag_u = (ur < 0) ? -ur : ur;
    if (mag_u > od) begin
      // User rotation wins: pass it on and drop the hold
      hold_on   = 1'b0;
      integ_acc = 0;
      rate      = ur;
      res.mode  = MODE_USER;
    end else if (vx * vx + vy * vy > mdb * mdb) begin
      // Capture the heading once when the hold engages
      if (!hold_on) begin
        hold_on    = 1'b1;
        target_hdg = yaw;
        integ_acc  = 0;
      end
      err = (target_hdg - yaw + WRAP_BIAS) % TURN_CDEG;
      if (err > HALF_CDEG) err -= TURN_CDEG;
      integ_acc += longint'(cfg_model.gain_i) * err * dt;
      integ_acc  = clamp_sym(integ_acc, longint'(cfg_model.integral_limit) * UNIT_SCALE);
      sum = longint'(cfg_model.gain_p) * err * GAIN_SCALE + integ_acc
          - longint'(cfg_model.gain_d) * gyro * GAIN_SCALE;
      // Round half up, then clamp to the output limit
      rate     = clamp_sym((sum + HALF_SCALE) >>> 24, longint'(cfg_model.output_limit));
      res.mode = MODE_HOLD;
    end else begin
      hold_on   = 1'b0;
      integ_acc = 0;
      rate      = 0;
      res.mode  = MODE_IDLE;
    end
    res.rate = rate[15:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued items, predict on each accepted transaction
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rate_cmd_q.push_back(hold_law_step(bus_stim.item));
      end
      // The slot frees up when nothing is offered or the offer was taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stim_q.size() != 0 && !(stim_q[0].wait_empty && rate_cmd_q.size() != 0) &&
            $urandom_range(99) >= src_idle_pct) begin
          bus_stim = stim_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_TDATA_W - IN_ITEM_W){1'b0}}, bus_stim.item};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    rate_cmd_t exp_cmd;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rate_cmd_q.size() == 0) begin
          $display("%0t: unexpected result, rate_out %0d mode %0d", $time,
                   $signed(m_axis_tdata), m_axis_tuser);
          errors++;
        end else begin
          exp_cmd = rate_cmd_q.pop_front();
          if (m_axis_tdata !== exp_cmd.rate) begin
            $display("%0t: rate_out mismatch, expected %0d, actual %0d", $time,
                     $signed(exp_cmd.rate), $signed(m_axis_tdata));
            errors++;
          end
          if (m_axis_tuser !== exp_cmd.mode) begin
            $display("%0t: mode mismatch, expected %0d, actual %0d", $time,
                     exp_cmd.mode, m_axis_tuser);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Register writes and stimulus
  // --------------------------------------------------------------------------
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    // Transaction taken at this edge: mirror it in the model
    case (idx)
      REG_OMEGA_DB:  cfg_model.omega_deadband = val[14:0];
      REG_MOVE_DB:   cfg_model.move_deadband  = val[14:0];
      REG_GAIN_P:    cfg_model.gain_p         = val;
      REG_GAIN_I:    cfg_model.gain_i         = val;
      REG_GAIN_D:    cfg_model.gain_d         = val;
      REG_INTEG_LIM: cfg_model.integral_limit = val[14:0];
      REG_OUT_LIM:   cfg_model.output_limit   = val[14:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input int od, input int mdb, input int gp, input int gi,
                           input int gd, input int il, input int ol);
    write_register(REG_OMEGA_DB, CFG_DATA_W'(od));
    write_register(REG_MOVE_DB, CFG_DATA_W'(mdb));
    write_register(REG_GAIN_P, CFG_DATA_W'(gp));
    write_register(REG_GAIN_I, CFG_DATA_W'(gi));
    write_register(REG_GAIN_D, CFG_DATA_W'(gd));
    write_register(REG_INTEG_LIM, CFG_DATA_W'(il));
    write_register(REG_OUT_LIM, CFG_DATA_W'(ol));
  endtask

  task automatic push_item(input int vx, input int vy, input int ur, input int yaw,
                           input int gyro, input int dt, input bit hold_back = 1'b0);
    stim_t s;
    s.item.vel_x     = 16'(vx);
    s.item.vel_y     = 16'(vy);
    s.item.user_rate = 16'(ur);
    s.item.yaw_meas  = 17'(yaw);
    s.item.gyro_rate = 19'(gyro);
    s.item.step_time = 16'(dt);
    s.wait_empty     = hold_back;
    stim_q.push_back(s);
  endtask

  // Mostly hold runs with a drifting heading; the rest pass-through, idle and noise
  task automatic push_random_item();
    int pick, od, mdb, h, mag;
    logic signed [15:0] vx, vy, ur;
    logic signed [16:0] yaw;
    logic signed [18:0] gyro;
    logic        [15:0] dt;
    od  = cfg_model.omega_deadband;
    mdb = cfg_model.move_deadband;
    if ($urandom_range(15) == 0) gyro = 19'($urandom);
    else gyro = 19'(int'($urandom_range(400000)) - 200000);
    if ($urandom_range(7) == 0) dt = 16'($urandom_range(65535));
    else dt = 16'($urandom_range(140, 40));
    ur  = 16'(int'($urandom_range(2 * od)) - od);
    yaw = 17'(int'($urandom_range(72000)) - 36000);
    vx  = 16'($urandom);
    vy  = 16'($urandom);
    if (hold_left == 0) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        hold_left = $urandom_range(24, 1);
        yaw_walk  = int'($urandom_range(72000)) - 36000;
      end
    end else begin
      pick = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      // Occasionally jump anywhere in the 17-bit range, else drift a little
      if ($urandom_range(9) == 0) yaw_walk = int'($urandom_range(131071)) - 65536;
      else yaw_walk += int'($urandom_range(2000)) - 1000;
      yaw      = 17'(yaw_walk);
      yaw_walk = int'(yaw);
      if (longint'(vx) * vx + longint'(vy) * vy <= longint'(mdb) * mdb) vx = 16'sh8000;
    end else if (pick < 70) begin
      mag = $urandom_range(32768, od + 1);
      ur  = 16'((mag == 32768 || $urandom_range(1) == 1) ? -mag : mag);
    end else if (pick < 85) begin
      h  = mdb / 2;
      vx = 16'(int'($urandom_range(2 * h)) - h);
      vy = 16'(int'($urandom_range(2 * h)) - h);
      // Sit exactly on the translation deadband now and then
      if ($urandom_range(7) == 0) begin
        vx = 16'(($urandom_range(1) == 1) ? mdb : -mdb);
        vy = '0;
      end
    end else begin
      ur   = 16'($urandom);
      yaw  = 17'($urandom);
      gyro = 19'($urandom);
      dt   = 16'($urandom);
    end
    push_item(int'(vx), int'(vy), int'(ur), int'(yaw), int'(gyro), int'(dt),
              $urandom_range(99) == 0);
  endtask

  task automatic push_directed_items();
    // Rotation deadband edges and extremes, no translation
    push_item(0, 0, 0, 0, 0, 0);
    push_item(0, 0, 100, 0, 0, 0);
    push_item(0, 0, -100, 0, 0, 0);
    push_item(0, 0, 101, 0, 0, 0);
    push_item(0, 0, -101, 0, 0, 0);
    push_item(0, 0, -32768, 0, 0, 0);
    push_item(0, 0, 32767, 0, 0, 0);
    // Translation exactly on the deadband stays idle
    push_item(100, 0, 0, 0, 0, 0);
    push_item(60, -80, 0, 0, 0, 0);
    // Engage just above the deadband, target 170.00 deg
    push_item(61, 80, 0, 17000, 0, 65);
    // Error at +half turn, then wrapped from the far side
    push_item(-32768, -32768, 100, -1000, 200000, 65535);
    push_item(32767, 32767, -100, -18000, -200000, 65535);
    // Yaw outside a turn, gyro at the 19-bit extremes
    push_item(0, -32768, 0, 65535, 262143, 0);
    push_item(0, 32767, 0, -65536, -262144, 65535);
    // Saturate the integral, then the output
    push_item(-32768, 0, 0, -1000, 0, 65535);
    push_item(-32768, 0, 0, -1000, -200000, 65535);
    push_item(1000, 0, 0, 35000, 0, 100);
    // Release the hold, re-engage with a new target
    push_item(0, 0, 5000, 0, 0, 0);
    push_item(500, 500, 0, -20000, 0, 65);
    push_item(500, 500, 0, -19000, 12345, 655);
    push_item(0, 0, 0, 0, 0, 0);
    // Zero error, damping only: exact rounding ties on both sides of zero
    push_item(0, 300, 0, 0, 1, 1);
    push_item(0, 300, 0, 0, 4, 0);
    push_item(0, 300, 0, 0, -4, 0);
    push_item(-32768, -32768, 0, 0, -200000, 65535);
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (stim_q.size() != 0 || s_axis_tvalid || rate_cmd_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input int seg);
    case (seg)
      0: ;  // run on reset values
      // All registers at their top, data wider than the field gets masked
      1: write_all(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
      // Zero deadbands, P and D gains, zero integral limit, I gain at its top
      2: begin
        write_all(0, 0, 0, 16'hFFFF, 0, 0, 16'h7FFF);
        write_register(REG_SPARE, 16'h1234);
      end
      // Zero output limit forces the hold output to zero
      4: write_all(50, 1, 16'h0100, 16'hFFFF, 16'h0040, 16'h7FFF, 0);
      7: write_all(int'(CFG_RESET.omega_deadband), int'(CFG_RESET.move_deadband),
                   int'(CFG_RESET.gain_p), int'(CFG_RESET.gain_i), int'(CFG_RESET.gain_d),
                   int'(CFG_RESET.integral_limit), int'(CFG_RESET.output_limit));
      default: write_all($urandom_range(3000), $urandom_range(3000), $urandom_range(65535),
                         $urandom_range(65535), $urandom_range(1024),
                         $urandom_range(32767), $urandom_range(32767));
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      load_settings(seg);
      // Rotate through: no idling, sender idle, receiver stall, both
      case (seg % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin src_idle_pct = 30; sink_stall_pct = 30; end
      endcase
      hold_left = 0;
      if (seg == 0) push_directed_items();
      for (int n = 0; n < ITEMS_PER_SEG; n++) push_random_item();
      wait_drained();
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/yhpd_pkg.sv
design/yaw_hold_pi_damped.sv
design/yhpd_checker.sv
dv/testbench.sv
